### rtl/core/ilda_laser_frame_parser_top_macros.svh
// ----------------------------------------------------------------------------
// ILDA frame parser assertion macros
// Concurrent assertion shorthands shared by the parser RTL.
// ----------------------------------------------------------------------------
`ifndef ILDA_LASER_FRAME_PARSER_TOP_MACROS_SVH
`define ILDA_LASER_FRAME_PARSER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ILP_ASSERT_IMP(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ILP_ASSERT_NXT(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/ilp_pkg.sv
// ----------------------------------------------------------------------------
// ILDA frame parser package
// Result codes, record formats, shared types and record helpers.
// ----------------------------------------------------------------------------
package ilp_pkg;

  typedef logic [2:0] kind_t;

  localparam kind_t KIND_POINT      = 3'd0;
  localparam kind_t KIND_PALETTE    = 3'd1;
  localparam kind_t KIND_HEADER     = 3'd2;
  localparam kind_t KIND_BAD_TAG    = 3'd3;
  localparam kind_t KIND_BAD_FORMAT = 3'd4;
  localparam kind_t KIND_TRUNCATED  = 3'd5;

  typedef logic [2:0] fmt_t;

  localparam fmt_t FMT_3D_INDEXED = 3'd0;
  localparam fmt_t FMT_2D_INDEXED = 3'd1;
  localparam fmt_t FMT_PALETTE    = 3'd2;
  localparam fmt_t FMT_3D_TRUE    = 3'd4;
  localparam fmt_t FMT_2D_TRUE    = 3'd5;

  // Section tag characters.
  localparam logic [7:0] TAG_I = 8'h49;
  localparam logic [7:0] TAG_L = 8'h4C;
  localparam logic [7:0] TAG_D = 8'h44;
  localparam logic [7:0] TAG_A = 8'h41;

  localparam int RecDepth = 10;

  typedef logic [RecDepth-1:0][7:0] rec_bytes_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic               frame_end;
    logic               blank;
    logic [7:0]         color_index;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [63:0]        header_info;
    logic               file_closed;
  } result_t;

  function automatic logic format_ok(input logic [7:0] f);
    return (f == 8'(FMT_3D_INDEXED)) || (f == 8'(FMT_2D_INDEXED)) ||
           (f == 8'(FMT_PALETTE)) || (f == 8'(FMT_3D_TRUE)) ||
           (f == 8'(FMT_2D_TRUE));
  endfunction

  function automatic logic [3:0] record_size(input fmt_t f);
    logic [3:0] s;
    case (f)
      FMT_PALETTE:    s = 4'd3;
      FMT_2D_INDEXED: s = 4'd6;
      FMT_3D_INDEXED: s = 4'd8;
      FMT_2D_TRUE:    s = 4'd8;
      FMT_3D_TRUE:    s = 4'd10;
      default:        s = 4'd1;
    endcase
    return s;
  endfunction

endpackage

### rtl/core/ilp_byte_if.sv
// ----------------------------------------------------------------------------
// ILDA file byte channel
// Valid/ready channel that carries one file byte and its end-of-file mark.
// ----------------------------------------------------------------------------
interface ilp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       last_byte;

  modport source (output valid, output file_byte, output last_byte, input ready);
  modport sink (input valid, input file_byte, input last_byte, output ready);
endinterface

### rtl/core/ilp_result_if.sv
// ----------------------------------------------------------------------------
// ILDA parser result channel
// Valid/ready channel that carries one decoded header, record or error.
// ----------------------------------------------------------------------------
interface ilp_result_if;
  logic               valid;
  logic               ready;
  ilp_pkg::kind_t     kind;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic               frame_end;
  logic               blank;
  logic [7:0]         color_index;
  logic [7:0]         red;
  logic [7:0]         green;
  logic [7:0]         blue;
  logic [63:0]        header_info;
  logic               file_closed;

  modport source (output valid, output kind, output pos_x, output pos_y, output pos_z,
                  output frame_end, output blank, output color_index, output red,
                  output green, output blue, output header_info, output file_closed,
                  input ready);
  modport sink (input valid, input kind, input pos_x, input pos_y, input pos_z,
                input frame_end, input blank, input color_index, input red,
                input green, input blue, input header_info, input file_closed,
                output ready);
endinterface

### rtl/core/ilda_laser_frame_parser_top.sv
// ----------------------------------------------------------------------------
// ILDA laser frame parser
// Streams an ILDA image file one byte per transfer and reports headers,
// point and palette records, and format errors as result transfers.
// ----------------------------------------------------------------------------
// Flow: an accepted byte waits in the input register until the parser consumes
// it, and its result, if any, is loaded into the result register and offered.
// Throughput: one byte per cycle while the result sink keeps up, set by the
// single parse step between the input register and the result register.
// Reset: synchronous rst empties both registers and returns the parser to the
// start of a section header.
`include "ilda_laser_frame_parser_top_macros.svh"

module ilda_laser_frame_parser_top (
  input logic          clk,
  input logic          rst,
  ilp_byte_if.sink     stream,
  ilp_result_if.source result
);
  import ilp_pkg::*;

  // Input register: holds one accepted byte until the parser consumes it.
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // Result register: holds one finished result until its transfer.
  logic    out_valid;
  result_t out_data;

  // The parser consumes the held byte whenever the result register is free
  // or is being emptied in this same cycle, so a new byte can enter while a
  // result is still on offer as long as the sink keeps up.
  logic    advance;
  result_t step_res;
  logic    step_valid;

  assign advance      = in_valid && (!out_valid || result.ready);
  assign stream.ready = !in_valid || advance;

  ilp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .file_byte (in_byte),
    .last_byte (in_last),
    .res       (step_res),
    .res_valid (step_valid)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (stream.ready) begin
      in_valid <= stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      in_byte <= stream.file_byte;
      in_last <= stream.last_byte;
    end
  end

  // Bytes that finish nothing leave the result register empty; those that
  // finish a header, a record or an error load it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step_valid;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_valid) begin
      out_data <= step_res;
    end
  end

  assign result.valid       = out_valid;
  assign result.kind        = out_data.kind;
  assign result.pos_x       = out_data.pos_x;
  assign result.pos_y       = out_data.pos_y;
  assign result.pos_z       = out_data.pos_z;
  assign result.frame_end   = out_data.frame_end;
  assign result.blank       = out_data.blank;
  assign result.color_index = out_data.color_index;
  assign result.red         = out_data.red;
  assign result.green       = out_data.green;
  assign result.blue        = out_data.blue;
  assign result.header_info = out_data.header_info;
  assign result.file_closed = out_data.file_closed;

  `ILP_ASSERT_NXT(a_held_byte_kept, clk, rst, in_valid && !advance, in_valid && $stable(in_byte) && $stable(in_last), "held byte lost before parsing")
  `ILP_ASSERT_IMP(a_result_from_step, clk, rst, out_valid && !$past(out_valid), $past(advance), "result appeared without a parse step")
  `ILP_ASSERT_IMP(a_header_format, clk, rst, out_valid && out_data.kind == KIND_HEADER, out_data.header_info[63:56] == 8'd0 || out_data.header_info[63:56] == 8'd1 || out_data.header_info[63:56] == 8'd2 || out_data.header_info[63:56] == 8'd4 || out_data.header_info[63:56] == 8'd5, "header result with unknown format")
endmodule

### rtl/core/ilp_decode.sv
// ----------------------------------------------------------------------------
// ILDA record decoder
// Turns the bytes of one complete record into a point or palette result.
// ----------------------------------------------------------------------------
module ilp_decode (
  input  ilp_pkg::rec_bytes_t rec,
  input  ilp_pkg::fmt_t       fmt,
  output ilp_pkg::result_t    rec_res
);
  import ilp_pkg::*;

  always_comb begin
    rec_res = '0;
    if (fmt == FMT_PALETTE) begin
      rec_res.kind  = KIND_PALETTE;
      rec_res.red   = rec[0];
      rec_res.green = rec[1];
      rec_res.blue  = rec[2];
    end else begin
      rec_res.kind  = KIND_POINT;
      rec_res.pos_x = {rec[0], rec[1]};
      rec_res.pos_y = {rec[2], rec[3]};
      case (fmt)
        FMT_3D_INDEXED: begin
          rec_res.pos_z       = {rec[4], rec[5]};
          rec_res.frame_end   = rec[6][7];
          rec_res.blank       = rec[6][6];
          rec_res.color_index = rec[7];
        end
        FMT_2D_INDEXED: begin
          rec_res.frame_end   = rec[4][7];
          rec_res.blank       = rec[4][6];
          rec_res.color_index = rec[5];
        end
        FMT_3D_TRUE: begin
          rec_res.pos_z     = {rec[4], rec[5]};
          rec_res.frame_end = rec[6][7];
          rec_res.blank     = rec[6][6];
          rec_res.blue      = rec[7];
          rec_res.green     = rec[8];
          rec_res.red       = rec[9];
        end
        default: begin
          // Two-dimensional true color; status then blue, green, red.
          rec_res.frame_end = rec[4][7];
          rec_res.blank     = rec[4][6];
          rec_res.blue      = rec[5];
          rec_res.green     = rec[6];
          rec_res.red       = rec[7];
        end
      endcase
    end
  end
endmodule

### rtl/core/ilp_parser.sv
// ----------------------------------------------------------------------------
// ILDA section parser
// Header and record sequencing state with one-byte-per-step next-state logic.
// ----------------------------------------------------------------------------
`include "ilda_laser_frame_parser_top_macros.svh"

module ilp_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       file_byte,
  input  logic             last_byte,
  output ilp_pkg::result_t res,
  output logic             res_valid
);
  import ilp_pkg::*;

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_RECORDS = 2'd1;
  localparam logic [1:0] PH_DRAIN   = 2'd2;

  logic [1:0]  phase, phase_next;
  logic [4:0]  hpos, hpos_next;
  logic [3:0]  rpos, rpos_next;
  logic [15:0] left, left_next;
  fmt_t        fmt, fmt_next;
  logic [63:0] hdr, hdr_next;
  rec_bytes_t  rb, rb_next;

  logic        fault;
  kind_t       fault_kind;
  logic [2:0]  lane;
  logic [15:0] count;
  logic [15:0] left_dec;
  result_t     rec_res;

  ilp_decode u_decode (
    .rec     (rb_next),
    .fmt     (fmt),
    .rec_res (rec_res)
  );

  assign lane     = 3'(5'd30 - hpos);
  assign left_dec = 16'(left - 16'd1);

  always_comb begin
    phase_next = phase;
    hpos_next  = hpos;
    rpos_next  = rpos;
    left_next  = left;
    fmt_next   = fmt;
    hdr_next   = hdr;
    rb_next    = rb;
    res        = '0;
    res_valid  = 1'b0;
    fault      = 1'b0;
    fault_kind = KIND_TRUNCATED;
    count      = '0;

    case (phase)
      PH_HEADER: begin
        if (hpos == 5'd0) begin
          hdr_next = '0;
        end
        if (hpos < 5'd4) begin
          rb_next[{2'b00, hpos[1:0]}] = file_byte;
        end
        if (hpos == 5'd3 && (rb[0] != TAG_I || rb[1] != TAG_L || rb[2] != TAG_D ||
                             file_byte != TAG_A)) begin
          fault      = 1'b1;
          fault_kind = KIND_BAD_TAG;
        end else if (hpos == 5'd7 && !format_ok(file_byte)) begin
          fault      = 1'b1;
          fault_kind = KIND_BAD_FORMAT;
        end else begin
          if (hpos == 5'd7) begin
            fmt_next        = file_byte[2:0];
            hdr_next[63:56] = file_byte;
          end
          if (hpos >= 5'd24 && hpos <= 5'd30) begin
            hdr_next[{lane, 3'b000} +: 8] = file_byte;
          end
          if (hpos == 5'd31) begin
            count = hdr_next[55:40];
            if (last_byte && count != 16'd0) begin
              fault = 1'b1;
            end else begin
              res_valid       = 1'b1;
              res.kind        = KIND_HEADER;
              res.header_info = hdr_next;
              res.file_closed = last_byte;
              hpos_next       = '0;
              rpos_next       = '0;
              left_next       = count;
              phase_next      = (count != 16'd0) ? PH_RECORDS : PH_HEADER;
            end
          end else if (last_byte) begin
            fault = 1'b1;
          end else begin
            hpos_next = 5'(hpos + 5'd1);
          end
        end
      end

      PH_RECORDS: begin
        if (rpos < 4'(RecDepth)) begin
          rb_next[rpos] = file_byte;
        end
        if ((5'({1'b0, rpos}) + 5'd1) >= {1'b0, record_size(fmt)}) begin
          left_next = left_dec;
          rpos_next = '0;
          if (left_dec == 16'd0) begin
            res_valid       = 1'b1;
            res             = rec_res;
            res.file_closed = last_byte;
            phase_next      = PH_HEADER;
            hpos_next       = '0;
          end else if (last_byte) begin
            fault = 1'b1;
          end else begin
            res_valid = 1'b1;
            res       = rec_res;
          end
        end else if (last_byte) begin
          fault = 1'b1;
        end else begin
          rpos_next = 4'(rpos + 4'd1);
        end
      end

      default: begin
        if (last_byte) begin
          phase_next = PH_HEADER;
          hpos_next  = '0;
          rpos_next  = '0;
          left_next  = '0;
        end
      end
    endcase

    if (fault) begin
      res       = '0;
      res.kind  = fault_kind;
      res_valid = 1'b1;
      if (last_byte) begin
        phase_next = PH_HEADER;
        hpos_next  = '0;
        rpos_next  = '0;
        left_next  = '0;
      end else begin
        phase_next = PH_DRAIN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      hpos  <= '0;
      rpos  <= '0;
      left  <= '0;
      fmt   <= FMT_3D_INDEXED;
      hdr   <= '0;
    end else if (step) begin
      phase <= phase_next;
      hpos  <= hpos_next;
      rpos  <= rpos_next;
      left  <= left_next;
      fmt   <= fmt_next;
      hdr   <= hdr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      rb <= rb_next;
    end
  end

  `ILP_ASSERT_IMP(a_records_pending, clk, rst, phase == PH_RECORDS, left != 16'd0, "record phase with no records left")
  `ILP_ASSERT_IMP(a_rpos_in_record, clk, rst, phase == PH_RECORDS, rpos < record_size(fmt), "record position past record end")
  `ILP_ASSERT_NXT(a_hpos_advance, clk, rst, step && phase == PH_HEADER && !res_valid, hpos == 5'($past(hpos) + 5'd1), "header position did not advance")
endmodule
